FILE: hdl/assert_macros.svh
// Assertion macros used by the top-level converter RTL.
// Each macro expects clk and rst to be visible where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/xtl_pkg.sv
// Shared constants and the cube-root table generator for the XYZ to Lab converter.
// No dependencies; imported by every module of the block.
package xtl_pkg;

  localparam int IN_W       = 16;
  localparam int OUT_W      = 18;
  localparam int ROM_W      = 24;
  localparam int RECIP_W    = 32;
  localparam int PROD_W     = IN_W + RECIP_W;
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 32;

  localparam int LOOKUP_STAGES = 7;
  localparam int LAB_STAGES    = 3;
  localparam int NUM_STAGES    = LOOKUP_STAGES + LAB_STAGES;

  localparam logic [CFG_ADDR_W-1:0] REG_WHITE_X = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_WHITE_Y = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_WHITE_Z = 2'd2;

  localparam logic [RECIP_W-1:0] WHITE_X_RESET = 32'd45187826;
  localparam logic [RECIP_W-1:0] WHITE_Y_RESET = 32'd42949673;
  localparam logic [RECIP_W-1:0] WHITE_Z_RESET = 32'd39445710;

  localparam int L_SCALE  = 116;
  localparam int A_SCALE  = 500;
  localparam int B_SCALE  = 200;
  localparam int L_OFFSET = 16 << 8;
  localparam int OUT_MAX  = 131071;
  localparam int OUT_MIN  = -131072;

  typedef logic [ROM_W-1:0] rom_word_t;

  // Q1.23 value of f(i/n): linear segment below 0.008856, cube root above.
  function automatic rom_word_t cbrt_entry(input int unsigned i, input int unsigned n);
    logic [63:0]  num;
    logic [63:0]  den;
    logic [63:0]  q;
    logic [63:0]  qc;
    logic [127:0] cube;
    logic [127:0] lim;
    logic [24:0]  r;
    logic [24:0]  c;
    if (64'(i) * 64'd1000000 < 64'd8856 * 64'(n)) begin
      num = (64'd225823 * 64'(i) + 64'd4000 * 64'(n)) << 23;
      den = 64'd29000 * 64'(n);
      q   = 64'd0;
      for (int b = 23; b >= 0; b--) begin
        qc = q | (64'd1 << b);
        if (qc * den <= num) q = qc;
      end
      return ROM_W'(q);
    end
    lim = 128'(i) << 69;
    r   = 25'd0;
    for (int b = 24; b >= 0; b--) begin
      c    = r | (25'd1 << b);
      cube = 128'(c) * 128'(c) * 128'(c) * 128'(n);
      if (cube <= lim) r = c;
    end
    return ROM_W'(r);
  endfunction

endpackage

FILE: hdl/xtl_cbrt_rom.sv
// Cube-root table with two registered read ports.
// Contents are built at elaboration by xtl_pkg::cbrt_entry.
module xtl_cbrt_rom #(
  parameter int ENTRIES = 4096,
  localparam int AW = $clog2(ENTRIES)
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic [AW-1:0]            addr0,
  input  logic [AW-1:0]            addr1,
  output logic [xtl_pkg::ROM_W-1:0] data0,
  output logic [xtl_pkg::ROM_W-1:0] data1
);
  import xtl_pkg::*;

  rom_word_t rom [ENTRIES];

  for (genvar g = 0; g < ENTRIES; g++) begin : g_entry
    localparam rom_word_t VAL = cbrt_entry(g, ENTRIES);
    assign rom[g] = VAL;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data0 <= rom[addr0];
      data1 <= rom[addr1];
    end
  end

endmodule

FILE: hdl/xtl_lookup.sv
// One component: scale by white reciprocal, index the cube-root table, interpolate.
// Seven register stages; uses xtl_pkg and xtl_cbrt_rom.
module xtl_lookup #(
  parameter int TABLE_ENTRIES = 4096,
  localparam int NB = $clog2(TABLE_ENTRIES),
  localparam int F_W = NB + 34
) (
  input  logic                              clk,
  input  logic [xtl_pkg::LOOKUP_STAGES-1:0] adv,
  input  logic [xtl_pkg::IN_W-1:0]          v,
  input  logic [xtl_pkg::RECIP_W-1:0]       recip,
  output logic signed [F_W-1:0]             f
);
  import xtl_pkg::*;

  localparam int PW = PROD_W + NB;
  localparam int FW = PW - 24;
  localparam int IW = PW - 40;

  logic [PROD_W-1:0]  p;
  logic [PW-1:0]      pos;
  logic [NB-1:0]      idx;
  logic [NB-1:0]      idx1;
  logic [FW-1:0]      frac2;
  logic [FW-1:0]      frac3;
  rom_word_t          base3;
  rom_word_t          nxt3;
  logic [FW-1:0]      frac4;
  logic [ROM_W-1:0]   mag;
  logic               neg4;
  rom_word_t          base4;
  logic [FW+ROM_W-1:0] prod;
  logic               neg5;
  rom_word_t          base5;

  logic [IW-1:0]      idx_raw;
  logic [NB-1:0]      idx_next;
  logic signed [ROM_W:0] diff;
  logic [FW+7:0]      term;
  logic signed [F_W-1:0] base_ext;
  logic signed [F_W-1:0] term_ext;

  assign idx_raw  = pos[PW-1:40];
  assign idx_next = (idx_raw > IW'(TABLE_ENTRIES - 2)) ? NB'(TABLE_ENTRIES - 2)
                                                       : idx_raw[NB-1:0];
  assign diff     = $signed({1'b0, nxt3}) - $signed({1'b0, base3});
  assign term     = prod[FW+ROM_W-1:16];
  assign base_ext = $signed({{(F_W-ROM_W){1'b0}}, base5});
  assign term_ext = $signed({{(F_W-FW-8){1'b0}}, term});

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      p <= PROD_W'(v) * PROD_W'(recip);
    end
    if (adv[1]) begin
      pos <= PW'(p) * PW'(TABLE_ENTRIES);
    end
    if (adv[2]) begin
      idx   <= idx_next;
      idx1  <= idx_next + 1'b1;
      frac2 <= pos[PW-1:24] - FW'({idx_next, 16'd0});
    end
    if (adv[3]) begin
      frac3 <= frac2;
    end
    if (adv[4]) begin
      frac4 <= frac3;
      neg4  <= diff[ROM_W];
      mag   <= diff[ROM_W] ? ROM_W'(-diff) : ROM_W'(diff);
      base4 <= base3;
    end
    if (adv[5]) begin
      prod  <= (FW+ROM_W)'(frac4) * (FW+ROM_W)'(mag);
      neg5  <= neg4;
      base5 <= base4;
    end
    if (adv[6]) begin
      f <= neg5 ? base_ext - term_ext : base_ext + term_ext;
    end
  end

  xtl_cbrt_rom #(
    .ENTRIES (TABLE_ENTRIES)
  ) u_rom (
    .clk   (clk),
    .en    (adv[3]),
    .addr0 (idx),
    .addr1 (idx1),
    .data0 (base3),
    .data1 (nxt3)
  );

endmodule

FILE: hdl/xtl_lab.sv
// Lab combine: L = 116*fy - 16, a = 500*(fx - fy), b = 200*(fy - fz), saturated Q9.8.
// Three register stages; uses xtl_pkg.
module xtl_lab #(
  parameter int F_W = 46
) (
  input  logic                           clk,
  input  logic [xtl_pkg::LAB_STAGES-1:0] adv,
  input  logic signed [F_W-1:0]          fx,
  input  logic signed [F_W-1:0]          fy,
  input  logic signed [F_W-1:0]          fz,
  output logic [xtl_pkg::OUT_W-1:0]      l_val,
  output logic [xtl_pkg::OUT_W-1:0]      a_val,
  output logic [xtl_pkg::OUT_W-1:0]      b_val
);
  import xtl_pkg::*;

  localparam int D_W = F_W + 1;
  localparam int M_W = F_W + 11;
  localparam int S_W = M_W - 14;

  logic signed [D_W-1:0] dxy;
  logic signed [D_W-1:0] dyz;
  logic signed [F_W-1:0] fy1;
  logic signed [M_W-1:0] lr;
  logic signed [M_W-1:0] ar;
  logic signed [M_W-1:0] br;

  logic signed [S_W-1:0] ls;
  logic signed [S_W-1:0] as_q;
  logic signed [S_W-1:0] bs_q;

  function automatic logic [OUT_W-1:0] sat(input logic signed [S_W-1:0] x);
    if (x > S_W'(OUT_MAX)) return OUT_W'(OUT_MAX);
    if (x < S_W'(OUT_MIN)) return OUT_W'(OUT_MIN);
    return x[OUT_W-1:0];
  endfunction

  assign ls   = $signed({lr[M_W-1], lr[M_W-1:15]}) - S_W'(L_OFFSET);
  assign as_q = $signed({ar[M_W-1], ar[M_W-1:15]});
  assign bs_q = $signed({br[M_W-1], br[M_W-1:15]});

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      dxy <= D_W'(fx) - D_W'(fy);
      dyz <= D_W'(fy) - D_W'(fz);
      fy1 <= fy;
    end
    if (adv[1]) begin
      lr <= M_W'(fy1) * $signed(M_W'(L_SCALE));
      ar <= M_W'(dxy) * $signed(M_W'(A_SCALE));
      br <= M_W'(dyz) * $signed(M_W'(B_SCALE));
    end
    if (adv[2]) begin
      l_val <= sat(ls);
      a_val <= sat(as_q);
      b_val <= sat(bs_q);
    end
  end

endmodule

FILE: hdl/xyz_to_lab_converter.sv
// Top level of the XYZ to CIE Lab converter: stream ports, white-point registers,
// pipeline valid tracking. Uses xtl_pkg, xtl_lookup, xtl_lab, assert_macros.svh.
//
// Input words carry one XYZ pixel (unsigned Q8.8 per component) on s_tdata,
// with s_tlast marking the last pixel of a buffer. Output words carry L, a, b
// in signed Q9.8, saturated, on m_tdata with m_tlast copied through.
// The cfg port writes the three white-point reciprocals (unsigned Q0.32);
// write only while no pixel is in flight. Index 3 is ignored.
// One pixel is accepted every cycle while the receiver does not stall; the rate
// is set by the 10-stage pipeline, where each component runs its own lookup
// with a dual-read table port.
// Reset empties the pipeline and restores the D65 reciprocals; the table is
// constant and needs no fill.
// When the receiver stalls, each stage holds only if the stage after it is
// full, so bubbles close up; s_tready drops once all 10 stages hold words.
`include "assert_macros.svh"

module xyz_to_lab_converter #(
  parameter int TABLE_ENTRIES = 4096
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [47:0]                        s_tdata,   // x_val, y_val, z_val
  input  logic                               s_tlast,   // last_in
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [55:0]                        m_tdata,   // l_val, a_val, b_val, pad
  output logic                               m_tlast,   // last_out
  input  logic                               cfg_we,
  input  logic [xtl_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [xtl_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import xtl_pkg::*;

  localparam int F_W = $clog2(TABLE_ENTRIES) + 34;

  logic [RECIP_W-1:0]    white_x_recip;
  logic [RECIP_W-1:0]    white_y_recip;
  logic [RECIP_W-1:0]    white_z_recip;
  logic [NUM_STAGES-1:0] valid;
  logic [NUM_STAGES-1:0] last;
  logic [NUM_STAGES-1:0] adv;

  logic signed [F_W-1:0] fx;
  logic signed [F_W-1:0] fy;
  logic signed [F_W-1:0] fz;
  logic [OUT_W-1:0]      l_val;
  logic [OUT_W-1:0]      a_val;
  logic [OUT_W-1:0]      b_val;

  always_ff @(posedge clk) begin
    if (rst) begin
      white_x_recip <= WHITE_X_RESET;
      white_y_recip <= WHITE_Y_RESET;
      white_z_recip <= WHITE_Z_RESET;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_WHITE_X: white_x_recip <= cfg_wdata;
        REG_WHITE_Y: white_y_recip <= cfg_wdata;
        REG_WHITE_Z: white_z_recip <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // advance a stage when it is empty or the next one advances
  always_comb begin
    adv[NUM_STAGES-1] = !valid[NUM_STAGES-1] || m_tready;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      adv[k] = !valid[k] || adv[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      if (adv[0]) valid[0] <= s_tvalid;
      for (int k = 1; k < NUM_STAGES; k++) begin
        if (adv[k]) valid[k] <= valid[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0]) last[0] <= s_tlast;
    for (int k = 1; k < NUM_STAGES; k++) begin
      if (adv[k]) last[k] <= last[k-1];
    end
  end

  xtl_lookup #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_lookup_x (
    .clk   (clk),
    .adv   (adv[LOOKUP_STAGES-1:0]),
    .v     (s_tdata[15:0]),
    .recip (white_x_recip),
    .f     (fx)
  );

  xtl_lookup #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_lookup_y (
    .clk   (clk),
    .adv   (adv[LOOKUP_STAGES-1:0]),
    .v     (s_tdata[31:16]),
    .recip (white_y_recip),
    .f     (fy)
  );

  xtl_lookup #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_lookup_z (
    .clk   (clk),
    .adv   (adv[LOOKUP_STAGES-1:0]),
    .v     (s_tdata[47:32]),
    .recip (white_z_recip),
    .f     (fz)
  );

  xtl_lab #(.F_W(F_W)) u_lab (
    .clk   (clk),
    .adv   (adv[NUM_STAGES-1:LOOKUP_STAGES]),
    .fx    (fx),
    .fy    (fy),
    .fz    (fz),
    .l_val (l_val),
    .a_val (a_val),
    .b_val (b_val)
  );

  assign s_tready = adv[0];
  assign m_tvalid = valid[NUM_STAGES-1];
  assign m_tlast  = last[NUM_STAGES-1];
  assign m_tdata  = {2'b00, b_val, a_val, l_val};

  `ASSERT_SAME(a_bubble_ready, !(&valid), s_tready, "input stalled with a free stage")
  `ASSERT_SAME(a_full_stall, (&valid) && !m_tready, !s_tready, "input taken into a full pipe")
  `ASSERT_NEXT(a_fill_rate, 1'b1, $countones(valid) <= $past($countones(valid)) + 1,
               "more than one word entered in a cycle")

endmodule

FILE: test/xyz_to_lab_converter_tb.sv
`timescale 1ns / 100ps
// Self-checking bench for xyz_to_lab_converter: drives XYZ pixel words, predicts Lab
// from its own cube-root table and white-point copies, checks every output word.
// Depends on xtl_pkg and the xyz_to_lab_converter RTL.
module xyz_to_lab_converter_tb;
  import xtl_pkg::*;

  localparam int TBL_N   = 4096;
  localparam int LATENCY = 10;
  localparam int LIMIT   = 400000;
  localparam int N_PHASE = 8;
  localparam int PHASE_N = 220;
  localparam logic [CFG_ADDR_W-1:0] REG_NONE = 2'd3;

  typedef struct packed {
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] z;
    logic        last;
  } pixel_t;

  typedef struct packed {
    logic [17:0] l;
    logic [17:0] a;
    logic [17:0] b;
    logic        last;
  } lab_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [47:0]           s_tdata = '0;   // x_val, y_val, z_val
  logic                  s_tlast = 1'b0; // last_in
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [55:0]           m_tdata;        // l_val, a_val, b_val, pad
  logic                  m_tlast;        // last_out
  logic                  cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  logic [23:0] root_tbl [TBL_N];
  logic [31:0] recip_x = WHITE_X_RESET;
  logic [31:0] recip_y = WHITE_Y_RESET;
  logic [31:0] recip_z = WHITE_Z_RESET;

  pixel_t pixel_q[$];
  lab_t   lab_q[$];
  pixel_t on_bus;
  int     src_idle = 0;
  int     snk_stall = 0;
  int     errors = 0;
  int     n_sent = 0;
  int     n_checked = 0;
  int     cycles = 0;

  xyz_to_lab_converter #(.TABLE_ENTRIES(TBL_N)) u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  // Q1.23 entry for t = i/N: linear segment near black, cube root above
  function automatic logic [23:0] root_entry(input int i);
    logic [63:0]  num;
    logic [127:0] lim;
    logic [24:0]  r;
    logic [24:0]  c;
    if (64'(i) * 64'd1000000 < 64'd8856 * 64'(TBL_N)) begin
      num = (64'd225823 * 64'(i) + 64'd4000 * 64'(TBL_N)) << 23;
      return 24'(num / (64'd29000 * 64'(TBL_N)));
    end
    lim = 128'(i) << 69;
    r = '0;
    for (int k = 24; k >= 0; k--) begin
      c = r | (25'd1 << k);
      if (128'(c) * 128'(c) * 128'(c) * 128'(TBL_N) <= lim) r = c;
    end
    return r[23:0];
  endfunction

  function automatic logic signed [63:0] cube_root_at(input logic [15:0] v,
                                                       input logic [31:0] recip);
    logic [63:0]        pos;
    logic [63:0]        idx;
    logic [63:0]        frac;
    logic [63:0]        mag;
    logic [63:0]        term;
    logic signed [63:0] base;
    logic signed [63:0] diff;
    pos = 64'(v) * 64'(recip) * 64'(TBL_N);
    idx = pos >> 40;
    if (idx > 64'(TBL_N - 2)) idx = 64'(TBL_N - 2);
    frac = (pos - (idx << 40)) >> 24;
    base = 64'(root_tbl[idx]);
    diff = 64'(root_tbl[idx + 1]) - base;
    mag  = diff[63] ? 64'(-diff) : 64'(diff);
    term = (frac * mag) >> 16;
    return diff[63] ? base - $signed(term) : base + $signed(term);
  endfunction

  function automatic logic [17:0] clip18(input logic signed [63:0] v);
    if (v > 64'sd131071) return 18'h1ffff;
    if (v < -64'sd131072) return 18'h20000;
    return v[17:0];
  endfunction

  function automatic lab_t lab_of(input pixel_t p);
    logic signed [63:0] fx;
    logic signed [63:0] fy;
    logic signed [63:0] fz;
    lab_t r;
    fx = cube_root_at(p.x, recip_x);
    fy = cube_root_at(p.y, recip_y);
    fz = cube_root_at(p.z, recip_z);
    r.l = clip18(((fy * 64'sd116) >>> 15) - 64'sd4096);
    r.a = clip18(((fx - fy) * 64'sd500) >>> 15);
    r.b = clip18(((fy - fz) * 64'sd200) >>> 15);
    r.last = p.last;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [17:0] e, input logic [17:0] g);
    if (e !== g) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d (0x%05h), got %0d (0x%05h)",
               $time, name, $signed(e), e, $signed(g), g);
    end
  endtask

  // driver: hold the word until accepted, then load the next or idle
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        lab_q.push_back(lab_of(on_bus));
        n_sent++;
      end
      if (!s_tvalid || s_tready) begin
        if (pixel_q.size() != 0 && $urandom_range(99) >= src_idle) begin
          on_bus = pixel_q.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= {on_bus.z, on_bus.y, on_bus.x};
          s_tlast  <= on_bus.last;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor: compare each accepted word with the oldest prediction
  always @(posedge clk) begin
    lab_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        n_checked++;
        if (lab_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected word, expected none, got l=%0d a=%0d b=%0d last=%0b",
                   $time, $signed(m_tdata[17:0]), $signed(m_tdata[35:18]),
                   $signed(m_tdata[53:36]), m_tlast);
        end else begin
          want = lab_q.pop_front();
          check_field("l_val", want.l, m_tdata[17:0]);
          check_field("a_val", want.a, m_tdata[35:18]);
          check_field("b_val", want.b, m_tdata[53:36]);
          check_field("pad", 18'd0, 18'(m_tdata[55:54]));
          check_field("last_out", 18'(want.last), 18'(m_tlast));
        end
      end
      m_tready <= ($urandom_range(99) >= snk_stall);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("%0t: timeout, %0d words still expected", $time, lab_q.size());
      $display("xyz_to_lab_converter_tb: errors");
      $finish;
    end
  end

  task automatic push_pixel(input logic [15:0] x, input logic [15:0] y,
                            input logic [15:0] z, input logic last);
    pixel_q.push_back('{x: x, y: y, z: z, last: last});
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [31:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_WHITE_X: recip_x = val;
      REG_WHITE_Y: recip_y = val;
      REG_WHITE_Z: recip_z = val;
      default: ;
    endcase
  endtask

  task automatic drain();
    while (pixel_q.size() != 0 || s_tvalid || lab_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  // spread over the whole range, the in-table span, the linear segment and the edges
  function automatic logic [15:0] pick_comp(input logic [31:0] recip);
    logic [63:0] span;
    span = (recip == 0) ? 64'd65535 : (64'd1 << 40) / 64'(recip);
    if (span > 64'd65535) span = 64'd65535;
    case ($urandom_range(3))
      0: return 16'($urandom_range(65535));
      1: return 16'($urandom_range(32'(span)));
      2: return 16'($urandom_range(32'(span >> 6)));
      default: begin
        case ($urandom_range(3))
          0: return 16'd0;
          1: return 16'hffff;
          2: return 16'(span);
          default: return 16'(span - 1);
        endcase
      end
    endcase
  endfunction

  initial begin
    int src_pct [4] = '{0, 48, 0, 33};
    int snk_pct [4] = '{0, 0, 48, 33};
    logic [31:0] rx;
    logic [31:0] ry;
    logic [31:0] rz;
    for (int i = 0; i < TBL_N; i++) root_tbl[i] = root_entry(i);
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // D65 after reset: extremes, white point, threshold and top-of-table positions
    push_pixel(16'd0, 16'd0, 16'd0, 1'b0);
    push_pixel(16'hffff, 16'hffff, 16'hffff, 1'b1);
    push_pixel(16'd24332, 16'd25600, 16'd27874, 1'b0);
    push_pixel(16'hffff, 16'd0, 16'd0, 1'b0);
    push_pixel(16'd0, 16'hffff, 16'd0, 1'b0);
    push_pixel(16'd0, 16'd0, 16'hffff, 1'b1);
    push_pixel(16'd1, 16'd1, 16'd1, 1'b0);
    push_pixel(16'd2, 16'd3, 16'd4, 1'b0);
    push_pixel(16'd0, 16'd225, 16'd0, 1'b0);
    push_pixel(16'd0, 16'd231, 16'd0, 1'b0);
    push_pixel(16'd221, 16'd0, 16'd240, 1'b0);
    push_pixel(16'haaaa, 16'h5555, 16'haaaa, 1'b1);
    push_pixel(16'h5555, 16'haaaa, 16'h5555, 1'b0);
    push_pixel(16'd0, 16'd25594, 16'd0, 1'b0);
    push_pixel(16'd24332, 16'd0, 16'd27874, 1'b0);
    push_pixel(16'd0, 16'd25600, 16'd0, 1'b0);
    push_pixel(16'd24300, 16'd25600, 16'd0, 1'b1);
    drain();

    for (int ph = 0; ph < N_PHASE; ph++) begin
      case (ph)
        0: begin rx = WHITE_X_RESET; ry = WHITE_Y_RESET; rz = WHITE_Z_RESET; end
        1: begin rx = 32'h0100_0000; ry = 32'h0100_0000; rz = 32'h0100_0000; end
        2: begin rx = 32'd0; ry = WHITE_Y_RESET; rz = 32'hffff_ffff; end
        3: begin rx = 32'hffff_ffff; ry = 32'hffff_ffff; rz = 32'd0; end
        4: begin rx = $urandom; ry = $urandom; rz = $urandom; end
        5: begin
          rx = $urandom_range(32'h0400_0000, 32'h0001_0000);
          ry = $urandom_range(32'h0400_0000, 32'h0001_0000);
          rz = $urandom_range(32'h0400_0000, 32'h0001_0000);
        end
        6: begin rx = 32'd0; ry = 32'd0; rz = 32'd0; end
        default: begin rx = WHITE_X_RESET; ry = $urandom; rz = WHITE_Z_RESET; end
      endcase
      write_reg(REG_WHITE_X, rx);
      write_reg(REG_WHITE_Y, ry);
      write_reg(REG_WHITE_Z, rz);
      write_reg(REG_NONE, $urandom);
      src_idle  = src_pct[ph % 4];
      snk_stall = snk_pct[ph % 4];
      for (int n = 0; n < PHASE_N; n++)
        push_pixel(pick_comp(recip_x), pick_comp(recip_y), pick_comp(recip_z),
                   $urandom_range(7) == 0);
      drain();
    end

    $display("%0d pixels converted and %0d Lab words checked across %0d white-point settings",
             n_sent, n_checked, N_PHASE + 1);
    if (errors == 0) begin
      $display("xyz_to_lab_converter_tb: clean");
    end else begin
      $display("%0d mismatches", errors);
      $display("xyz_to_lab_converter_tb: errors");
    end
    $finish;
  end

endmodule

FILE: xyz_to_lab_converter.f
+incdir+hdl
hdl/xtl_pkg.sv
hdl/xtl_cbrt_rom.sv
hdl/xtl_lookup.sv
hdl/xtl_lab.sv
hdl/xyz_to_lab_converter.sv
test/xyz_to_lab_converter_tb.sv
